>>> design/swfrm_pkg.sv
// ----------------------------------------------------------------------------
// swfrm_pkg
// shared constants, control word, status and microcode table of the meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swfrm_pkg;

  localparam int RING_DEPTH = 8192;
  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int STAMP_W = 32;
  localparam int WIN_W = 16;
  localparam int WINDOW_RESET = 1000;
  localparam int RATE_W = 31;
  localparam int MULT = 256000;
  localparam int MULT_W = 18;
  localparam int NUM_W = IDX_W + MULT_W;
  localparam int QUOT_X_W = (NUM_W > RATE_W) ? NUM_W : RATE_W;
  localparam int ITER_W = $clog2(NUM_W);
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int PC_W = 3;
  localparam int COND_W = 3;

  localparam logic [ADDR_W-3:0] REG_WINDOW_MS = 1'b0;

  localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [PC_W-1:0] STEP_READ = 3'd1;
  localparam logic [PC_W-1:0] STEP_WALK = 3'd2;
  localparam logic [PC_W-1:0] STEP_LOAD = 3'd3;
  localparam logic [PC_W-1:0] STEP_DIV = 3'd4;
  localparam logic [PC_W-1:0] STEP_WAIT = 3'd5;
  localparam logic [PC_W-1:0] STEP_OUT = 3'd6;

  localparam logic [COND_W-1:0] COND_NONE = 3'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS = 3'd1;
  localparam logic [COND_W-1:0] COND_IDLE = 3'd2;
  localparam logic [COND_W-1:0] COND_WALK = 3'd3;
  localparam logic [COND_W-1:0] COND_DIV = 3'd4;
  localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd5;

  typedef struct packed {
    logic ready;
    logic rd_tail;
    logic walk;
    logic load_div;
    logic div_step;
    logic load_out;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic walk_more;
    logic div_busy;
    logic out_busy;
  } stat_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    c = '0;
    case (pc)
      STEP_IDLE: begin
        c.ready = 1'b1;
        c.cond = COND_IDLE;
        c.target = STEP_IDLE;
      end
      STEP_READ: begin
        c.rd_tail = 1'b1;
        c.cond = COND_NONE;
      end
      STEP_WALK: begin
        c.walk = 1'b1;
        c.cond = COND_WALK;
        c.target = STEP_READ;
      end
      STEP_LOAD: begin
        c.load_div = 1'b1;
        c.cond = COND_NONE;
      end
      STEP_DIV: begin
        c.div_step = 1'b1;
        c.cond = COND_DIV;
        c.target = STEP_DIV;
      end
      STEP_WAIT: begin
        c.cond = COND_OUT_BUSY;
        c.target = STEP_WAIT;
      end
      STEP_OUT: begin
        c.load_out = 1'b1;
        c.cond = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
      default: begin
        c.cond = COND_ALWAYS;
        c.target = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> design/swfrm_seq.sv
// ----------------------------------------------------------------------------
// swfrm_seq
// step counter and microcode table with conditional jumps
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swfrm_seq (
  input  logic             clk,
  input  logic             rst,
  input  swfrm_pkg::stat_t stat,
  output swfrm_pkg::ctrl_t ctrl
);
  import swfrm_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            taken;

  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.cond)
      COND_NONE:     taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_IDLE:     taken = !stat.accept;
      COND_WALK:     taken = stat.walk_more;
      COND_DIV:      taken = stat.div_busy;
      COND_OUT_BUSY: taken = stat.out_busy;
      default:       taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> design/swfrm_ring.sv
// ----------------------------------------------------------------------------
// swfrm_ring
// timestamp ring store, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swfrm_ring (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 we,
  input  logic [swfrm_pkg::IDX_W-1:0]          waddr,
  input  logic [swfrm_pkg::STAMP_W-1:0]        wdata,
  input  logic                                 re,
  input  logic [swfrm_pkg::IDX_W-1:0]          raddr,
  output logic [swfrm_pkg::STAMP_W-1:0]        rdata
);
  import swfrm_pkg::*;

  logic [STAMP_W-1:0] mem [RING_DEPTH];
  logic [STAMP_W-1:0] mem_q;
  logic               zero_written;
  logic               rd_blank;

  // entries are written in ring order from one, so only entry zero can be
  // read before it has been written
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_written <= 1'b0;
      rd_blank <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        zero_written <= 1'b1;
      end
      if (re) begin
        rd_blank <= (raddr == '0) && !zero_written;
      end
    end
  end

  assign rdata = rd_blank ? '0 : mem_q;

endmodule

>>> design/swfrm_div.sv
// ----------------------------------------------------------------------------
// swfrm_div
// restoring divider, one quotient bit per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swfrm_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [swfrm_pkg::NUM_W-1:0]   num,
  input  logic [swfrm_pkg::STAMP_W-1:0] den,
  output logic                          busy,
  output logic [swfrm_pkg::NUM_W-1:0]   quot
);
  import swfrm_pkg::*;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(NUM_W - 1);

  logic [STAMP_W-1:0] rem;
  logic [STAMP_W-1:0] divisor;
  logic [ITER_W-1:0]  iter;
  logic [STAMP_W:0]   shifted;
  logic [STAMP_W:0]   diff;
  logic               fits;

  always_comb begin
    shifted = {rem, quot[NUM_W-1]};
    diff = shifted - {1'b0, divisor};
    fits = shifted >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quot <= num;
      divisor <= den;
      iter <= '0;
    end else if (step) begin
      rem <= fits ? diff[STAMP_W-1:0] : shifted[STAMP_W-1:0];
      quot <= {quot[NUM_W-2:0], fits};
      iter <= iter + ITER_W'(1);
    end
  end

  assign busy = iter != ITER_LAST;

endmodule

>>> design/sliding_window_frame_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_frame_rate_meter
// frame rate over a sliding millisecond window, unsigned q8 result
// steps: accept in idle, then for each tail step a ring read and a walk, then
// the divider load and the one-bit-per-cycle divide, then a wait while the
// previous result waits for its output transaction, then the output load; a
// new input transaction is taken only after the result is loaded
// reset: synchronous; no clearing pass, unwritten entry zero reads as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_frame_rate_meter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [swfrm_pkg::STAMP_W-1:0]       time_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [swfrm_pkg::RATE_W-1:0]        rate_q8,
  output logic                                window_empty,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swfrm_pkg::ADDR_W-1:0]        paddr,
  input  logic [swfrm_pkg::DATA_W-1:0]        pwdata,
  output logic [swfrm_pkg::DATA_W-1:0]        prdata,
  output logic                                pready
);
  import swfrm_pkg::*;

  localparam logic [QUOT_X_W-1:0] RATE_MAX = QUOT_X_W'({RATE_W{1'b1}});

  ctrl_t ctrl;
  stat_t stat;

  logic [WIN_W-1:0]   window_ms;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   tail_next;
  logic [STAMP_W-1:0] now_ms;
  logic [STAMP_W-1:0] tail_stamp;
  logic [STAMP_W-1:0] span;
  logic [IDX_W:0]     count_wide;
  logic [IDX_W-1:0]   count;
  logic [NUM_W-1:0]   numerator;
  logic [NUM_W-1:0]   quot;
  logic [QUOT_X_W-1:0] quot_x;
  logic               div_busy;
  logic               accept;
  logic               walk_more;
  logic               empty;
  logic               zero_span;
  logic               cfg_write;

  swfrm_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  swfrm_ring u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (accept),
    .waddr (head_next),
    .wdata (time_ms),
    .re    (ctrl.rd_tail),
    .raddr (tail),
    .rdata (tail_stamp)
  );

  swfrm_div u_div (
    .clk  (clk),
    .load (ctrl.load_div),
    .step (ctrl.div_step),
    .num  (numerator),
    .den  (span),
    .busy (div_busy),
    .quot (quot)
  );

  // configuration
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_WINDOW_MS;
  assign prdata = (paddr[ADDR_W-1:2] == REG_WINDOW_MS) ? DATA_W'(window_ms) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WIN_W'(WINDOW_RESET);
    end else if (cfg_write) begin
      window_ms <= pwdata[WIN_W-1:0];
    end
  end

  // datapath
  assign in_ready = ctrl.ready;
  assign accept = in_valid && in_ready;
  assign head_next = (head == IDX_W'(RING_DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign tail_next = (tail == IDX_W'(RING_DEPTH - 1)) ? '0 : tail + IDX_W'(1);
  assign span = now_ms - tail_stamp;
  assign walk_more = (tail != head) && (span > STAMP_W'(window_ms));
  assign numerator = NUM_W'(count) * NUM_W'(MULT);

  always_comb begin
    if (head >= tail) begin
      count_wide = {1'b0, head} - {1'b0, tail};
    end else begin
      count_wide = {1'b0, head} + (IDX_W + 1)'(RING_DEPTH) - {1'b0, tail};
    end
    count = count_wide[IDX_W-1:0];
    quot_x = QUOT_X_W'(quot);
  end

  assign stat.accept = accept;
  assign stat.walk_more = walk_more;
  assign stat.div_busy = div_busy;
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (accept) begin
        head <= head_next;
      end
      if (ctrl.walk && walk_more) begin
        tail <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_ms <= time_ms;
    end
    if (ctrl.load_div) begin
      empty <= tail == head;
      zero_span <= span == '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      window_empty <= empty;
      if (empty || zero_span) begin
        rate_q8 <= '0;
      end else if (quot_x > RATE_MAX) begin
        rate_q8 <= RATE_MAX[RATE_W-1:0];
      end else begin
        rate_q8 <= quot_x[RATE_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_empty_zero_rate: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_empty |-> rate_q8 == '0)
    else $error("empty window with nonzero rate");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input transaction taken while busy");

  a_out_reg_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> !out_valid)
    else $error("result loaded over a pending one");

  a_walk_stops_at_head: assert property (@(posedge clk) disable iff (rst)
    ctrl.walk && walk_more |=> $past(tail) != $past(head))
    else $error("tail walked past head");
`endif

endmodule
